/* design/eesd_pkg.sv */
// Shared types and constants for the event stream decoder.
package eesd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PosWidth   = 25;
   localparam int unsigned CoordWidth = 14;
   localparam int unsigned BufWidth   = 16;
   localparam int unsigned HeldWidth  = 3;
   localparam int unsigned OffWidth   = 10;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned CsrDataWidth = 25;

   localparam logic [CsrIdxWidth-1:0] CSR_RUN_CODE_MODE     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SUPER_RES_MODE    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FRAME_PIXEL_COUNT = 2'd2;

   localparam logic RUN_CODE_7 = 1'b0;
   localparam logic RUN_CODE_8 = 1'b1;

   localparam logic [1:0] SUPER_RES_X1 = 2'd0;
   localparam logic [1:0] SUPER_RES_X2 = 2'd1;
   localparam logic [1:0] SUPER_RES_X4 = 2'd2;

   localparam logic [3:0] SYMBOL_XOR = 4'hA;
   localparam logic [7:0] RUN_MASK_7 = 8'd127;
   localparam logic [7:0] RUN_MASK_8 = 8'd255;
   localparam logic [PosWidth-1:0] FRAME_PIXEL_COUNT_RESET = 25'd16777216;

   typedef struct packed {
      logic                 run_code_mode;
      logic [1:0]           super_res_mode;
      logic [PosWidth-1:0]  frame_pixel_count;
   } cfg_type;

   typedef struct packed {
      logic [BufWidth-1:0]  bit_buffer;
      logic [HeldWidth-1:0] bits_held;
      logic                 expect_symbol;
      logic [PosWidth-1:0]  pixel_position;
      logic                 frame_finished;
   } state_type;

   typedef struct packed {
      logic                  event_valid;
      logic [CoordWidth-1:0] event_x;
      logic [CoordWidth-1:0] event_y;
      logic                  frame_done;
      logic                  overrun_error;
   } result_type;

endpackage

/* design/eesd_step_logic.sv */
// Per-item decode: merges one byte into the bit buffer and parses up to three codes.
module eesd_step_logic #(
   parameter int unsigned ROW_BITS = 12
) (
   input  eesd_pkg::cfg_type    cfg,
   input  eesd_pkg::state_type  state_cur,
   input  logic [7:0]           data_byte,
   input  logic                 first_of_frame,
   output eesd_pkg::state_type  state_nxt,
   output eesd_pkg::result_type result,
   output logic                 result_valid
);

   localparam int unsigned Steps = 3;

   always_comb begin
      eesd_pkg::state_type st;
      logic [eesd_pkg::BufWidth-1:0] buf_v;
      logic [3:0]                    held;
      logic                          expsym;
      logic [eesd_pkg::PosWidth-1:0] base;
      logic [eesd_pkg::OffWidth-1:0] off;
      logic [eesd_pkg::PosWidth:0]   sum;
      logic [eesd_pkg::PosWidth-1:0] pos;
      logic [3:0]                    rbits;
      logic [7:0]                    rmask;
      logic [7:0]                    run;
      logic [3:0]                    sym;
      logic [eesd_pkg::CoordWidth-1:0] col;
      logic [eesd_pkg::CoordWidth-1:0] row;
      logic                          stop;
      logic                          ev;
      logic                          done;
      logic                          over;
      logic [eesd_pkg::CoordWidth-1:0] ex;
      logic [eesd_pkg::CoordWidth-1:0] ey;

      st = state_cur;
      if (first_of_frame) begin
         st = '0;
      end
      ev   = 1'b0;
      done = 1'b0;
      over = 1'b0;
      ex   = '0;
      ey   = '0;
      stop = 1'b0;
      off  = '0;
      base = st.pixel_position;
      sum  = '0;
      pos  = '0;
      run  = '0;
      sym  = '0;
      col  = '0;
      row  = '0;
      rbits = (cfg.run_code_mode == eesd_pkg::RUN_CODE_8) ? 4'd8 : 4'd7;
      rmask = (cfg.run_code_mode == eesd_pkg::RUN_CODE_8) ?
              eesd_pkg::RUN_MASK_8 : eesd_pkg::RUN_MASK_7;
      buf_v  = st.bit_buffer | (16'(data_byte) << st.bits_held);
      held   = {1'b0, st.bits_held} + 4'd8;
      expsym = st.expect_symbol;

      for (int i = 0; i < Steps; i++) begin
         if (!stop && !st.frame_finished) begin
            if (!expsym) begin
               if (held < rbits) begin
                  stop = 1'b1;
               end else begin
                  run   = buf_v[7:0] & rmask;
                  buf_v = buf_v >> rbits;
                  held  = held - rbits;
                  off   = off + 10'(run);
                  sum   = {1'b0, base} + 26'(off);
                  if (sum == {1'b0, cfg.frame_pixel_count}) begin
                     done = 1'b1;
                     stop = 1'b1;
                  end else if (sum > {1'b0, cfg.frame_pixel_count}) begin
                     over = 1'b1;
                     stop = 1'b1;
                  end else if (run != rmask) begin
                     expsym = 1'b1;
                  end
               end
            end else begin
               if (held < 4'd4) begin
                  stop = 1'b1;
               end else begin
                  sym   = buf_v[3:0] ^ eesd_pkg::SYMBOL_XOR;
                  buf_v = buf_v >> 4;
                  held  = held - 4'd4;
                  pos   = base + 25'(off);
                  col   = 14'(pos[ROW_BITS-1:0]);
                  row   = 14'(pos >> ROW_BITS);
                  case (cfg.super_res_mode)
                     eesd_pkg::SUPER_RES_X2: begin
                        ex = {col[12:0], sym[1]};
                        ey = {row[12:0], sym[3]};
                     end
                     eesd_pkg::SUPER_RES_X4: begin
                        ex = {col[11:0], sym[1:0]};
                        ey = {row[11:0], sym[3:2]};
                     end
                     default: begin
                        ex = col;
                        ey = row;
                     end
                  endcase
                  ev     = 1'b1;
                  off    = off + 10'd1;
                  expsym = 1'b0;
               end
            end
         end
      end

      state_nxt = st;
      if (!st.frame_finished) begin
         state_nxt.bit_buffer     = buf_v;
         state_nxt.bits_held      = held[eesd_pkg::HeldWidth-1:0];
         state_nxt.expect_symbol  = expsym;
         state_nxt.pixel_position = base + 25'(off);
         state_nxt.frame_finished = done | over;
      end

      result.event_valid   = ev;
      result.event_x       = ex;
      result.event_y       = ey;
      result.frame_done    = done;
      result.overrun_error = over;
      result_valid         = ev | done | over;
   end

endmodule

/* design/eer_event_stream_decoder_top.sv */
// Top level of the electron event stream decoder: input stage, state, result register.
// Usage:
//   Bytes of a compressed frame enter on the req_ channel (valid/ready), one byte
//   per item, with req_first_of_frame set on the first byte of each frame.
//   Each byte yields at most one item on the rsp_ channel: the last event that
//   the byte completed and/or the frame end or overrun flags. Bytes that finish
//   no event and no frame produce nothing.
//   From input accept, the byte sits in the input register while the decode logic
//   computes, then loads the result register, which drives rsp_valid.
//   Throughput is one byte per cycle unless rsp_ready stalls; the bit buffer, pixel
//   position and flags update in the same cycle the byte leaves the input register.
//   When the receiver holds rsp_ready low, the result register holds its item
//   and the input register holds the next byte; req_ready drops only when both
//   are full.
//   The csr_ port writes run code width, super-resolution factor and frame pixel
//   count by index; write it only while no items are in flight.
//   Synchronous reset clears the decoder state, both stages and the registers
//   (7-bit runs, factor 1, frame count 16777216).
module eer_event_stream_decoder_top #(
   parameter int unsigned ROW_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_valid,
   output logic [13:0] rsp_event_x,
   output logic [13:0] rsp_event_y,
   output logic        rsp_frame_done,
   output logic        rsp_overrun_error,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_wdata
);

   eesd_pkg::cfg_type    cfg_ff, cfg_in;
   eesd_pkg::state_type  state_ff, state_in, state_nxt;
   eesd_pkg::result_type rsp_ff, result;
   logic                 result_valid;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_first_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 process;
   logic                 req_take;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            eesd_pkg::CSR_RUN_CODE_MODE:     cfg_in.run_code_mode = csr_wdata[0];
            eesd_pkg::CSR_SUPER_RES_MODE:    cfg_in.super_res_mode = csr_wdata[1:0];
            eesd_pkg::CSR_FRAME_PIXEL_COUNT: cfg_in.frame_pixel_count = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   eesd_step_logic #(
      .ROW_BITS(ROW_BITS)
   ) u_step (
      .cfg           (cfg_ff),
      .state_cur     (state_ff),
      .data_byte     (in_byte_ff),
      .first_of_frame(in_first_ff),
      .state_nxt     (state_nxt),
      .result        (result),
      .result_valid  (result_valid)
   );

   assign state_in     = process ? state_nxt : state_ff;
   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? (in_valid_ff && result_valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_code_mode     <= eesd_pkg::RUN_CODE_7;
         cfg_ff.super_res_mode    <= eesd_pkg::SUPER_RES_X1;
         cfg_ff.frame_pixel_count <= eesd_pkg::FRAME_PIXEL_COUNT_RESET;
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_of_frame;
      end
      if (process && result_valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_valid   = rsp_ff.event_valid;
   assign rsp_event_x       = rsp_ff.event_x;
   assign rsp_event_y       = rsp_ff.event_y;
   assign rsp_frame_done    = rsp_ff.frame_done;
   assign rsp_overrun_error = rsp_ff.overrun_error;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.frame_done && rsp_ff.overrun_error))
      else $error("frame end and overrun reported together");

   a_result_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.event_valid || rsp_ff.frame_done || rsp_ff.overrun_error))
      else $error("result item carries no event and no flag");

   a_finished_frame_quiet: assert property (@(posedge clock) disable iff (reset)
      (process && state_ff.frame_finished && !in_first_ff) |=>
         ($stable(state_ff) && !rsp_valid_ff))
      else $error("finished frame changed state on a byte");

   a_finish_reported: assert property (@(posedge clock) disable iff (reset)
      (process && !state_ff.frame_finished && state_nxt.frame_finished) |=> rsp_valid_ff)
      else $error("frame end without a result item");

endmodule

/* dv/tb.sv */
// Testbench for eer_event_stream_decoder_top: encoded frame streams, predicted events, checks.
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_BITS = 12;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_first_of_frame;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_event_valid;
   logic [13:0] rsp_event_x;
   logic [13:0] rsp_event_y;
   logic        rsp_frame_done;
   logic        rsp_overrun_error;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [24:0] csr_wdata;

   eer_event_stream_decoder_top #(.ROW_BITS(ROW_BITS)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_first_of_frame (req_first_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_event_x        (rsp_event_x),
      .rsp_event_y        (rsp_event_y),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_overrun_error  (rsp_overrun_error),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // decoder configuration and state as predicted
   logic                          cfg_run8  = eesd_pkg::RUN_CODE_7;
   logic [1:0]                    cfg_sres  = eesd_pkg::SUPER_RES_X1;
   logic [eesd_pkg::PosWidth-1:0] cfg_count = eesd_pkg::FRAME_PIXEL_COUNT_RESET;
   logic [15:0]                   dec_buf = '0;
   int                            dec_held = 0;
   bit                            dec_want_symbol = 0;
   logic [eesd_pkg::PosWidth-1:0] dec_pos = '0;
   bit                            dec_finished = 0;

   eesd_pkg::result_type pending_results[$];
   int         mismatch_count = 0;
   int         items_sent = 0;
   bit         tx_idle = 1;
   bit         rx_idle = 1;
   int         rx_wait = 0;
   int         rx_hold = 0;

   // frame encoder state
   logic [31:0] gen_acc;
   int          gen_nacc;
   int unsigned gen_pos;
   logic        gen_first;

   function automatic int unsigned run_mask();
      return 32'(cfg_run8 ? eesd_pkg::RUN_MASK_8 : eesd_pkg::RUN_MASK_7);
   endfunction

   function automatic int run_width();
      return cfg_run8 ? 8 : 7;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic first);
      eesd_pkg::result_type r;
      int unsigned run, total, col, row;
      logic [3:0]  sym;
      bit          stop;
      r = '0;
      stop = 0;
      if (first) begin
         dec_buf = '0;
         dec_held = 0;
         dec_want_symbol = 0;
         dec_pos = '0;
         dec_finished = 0;
      end
      if (dec_finished) return;
      dec_held = dec_held & 7;
      dec_buf = dec_buf | (16'(b) << dec_held);
      dec_held += 8;
      while (!stop) begin
         if (!dec_want_symbol) begin
            if (dec_held < run_width()) begin
               stop = 1;
            end else begin
               run = dec_buf & run_mask();
               dec_buf >>= run_width();
               dec_held -= run_width();
               total = dec_pos + run;
               dec_pos = 25'(total);
               if (total == cfg_count) begin
                  r.frame_done = 1'b1;
                  dec_finished = 1;
                  stop = 1;
               end else if (total > cfg_count) begin
                  r.overrun_error = 1'b1;
                  dec_finished = 1;
                  stop = 1;
               end else if (run != run_mask()) begin
                  dec_want_symbol = 1;
               end
            end
         end else begin
            if (dec_held < 4) begin
               stop = 1;
            end else begin
               sym = dec_buf[3:0] ^ eesd_pkg::SYMBOL_XOR;
               dec_buf >>= 4;
               dec_held -= 4;
               col = dec_pos & ((1 << ROW_BITS) - 1);
               row = 32'(dec_pos) >> ROW_BITS;
               case (cfg_sres)
                  eesd_pkg::SUPER_RES_X2: begin
                     col = (col << 1) | sym[1];
                     row = (row << 1) | sym[3];
                  end
                  eesd_pkg::SUPER_RES_X4: begin
                     col = (col << 2) | sym[1:0];
                     row = (row << 2) | sym[3:2];
                  end
                  default: ;
               endcase
               r.event_valid = 1'b1;
               r.event_x = 14'(col);
               r.event_y = 14'(row);
               dec_pos = dec_pos + 1'b1;
               dec_want_symbol = 0;
            end
         end
      end
      if (r.event_valid || r.frame_done || r.overrun_error) pending_results.push_back(r);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      eesd_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual ev=%0d x=%0d y=%0d %s%0d %s%0d",
                     $time, rsp_event_valid, rsp_event_x, rsp_event_y, "done=",
                     rsp_frame_done, "ovr=", rsp_overrun_error);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("event_valid", 32'(want.event_valid), 32'(rsp_event_valid));
            check_field("event_x", 32'(want.event_x), 32'(rsp_event_x));
            check_field("event_y", 32'(want.event_y), 32'(rsp_event_y));
            check_field("frame_done", 32'(want.frame_done), 32'(rsp_frame_done));
            check_field("overrun_error", 32'(want.overrun_error), 32'(rsp_overrun_error));
         end
         rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_ready = 1'b0;
            rx_hold--;
         end else if (rx_wait > 0) begin
            rsp_ready = 1'b0;
            rx_wait--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      gap = tx_idle ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_byte = b;
      req_first_of_frame = first;
      do @(posedge clock); while (!req_ready);
      decode_byte(b, first);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [24:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input logic run8, input logic [1:0] sres, input logic [24:0] pixels);
      settle();
      write_csr(eesd_pkg::CSR_RUN_CODE_MODE, 25'(run8));
      write_csr(eesd_pkg::CSR_SUPER_RES_MODE, 25'(sres));
      write_csr(eesd_pkg::CSR_FRAME_PIXEL_COUNT, pixels);
      cfg_run8 = run8;
      cfg_sres = sres;
      cfg_count = pixels;
   endtask

   task automatic push_bits(input int unsigned value, input int n);
      gen_acc = gen_acc | (32'(value) << gen_nacc);
      gen_nacc += n;
      while (gen_nacc >= 8) begin
         send_byte(gen_acc[7:0], gen_first);
         gen_first = 1'b0;
         gen_acc >>= 8;
         gen_nacc -= 8;
      end
   endtask

   task automatic open_frame();
      gen_acc = '0;
      gen_nacc = 0;
      gen_pos = 0;
      gen_first = 1'b1;
   endtask

   task automatic flush_frame();
      if (gen_nacc > 0)
         push_bits($urandom_range(0, 255) & ((1 << (8 - gen_nacc)) - 1), 8 - gen_nacc);
   endtask

   task automatic gen_events(input int n, input int skip_pct);
      int unsigned rem, lim;
      int unsigned r;
      repeat (n) begin
         if (gen_pos < cfg_count) begin
            rem = cfg_count - gen_pos;
            if (rem > run_mask() && $urandom_range(0, 99) < skip_pct) begin
               push_bits(run_mask(), run_width());
               gen_pos += run_mask();
            end else begin
               lim = rem - 1;
               if (lim > run_mask() - 1) lim = run_mask() - 1;
               if ($urandom_range(0, 1) && lim > 3) lim = 3;
               r = $urandom_range(0, lim);
               push_bits(r, run_width());
               push_bits($urandom_range(0, 15), 4);
               gen_pos += r + 1;
            end
         end
      end
   endtask

   task automatic close_frame();
      int unsigned rem, r;
      while (cfg_count - gen_pos > run_mask()) begin
         push_bits(run_mask(), run_width());
         gen_pos += run_mask();
      end
      rem = cfg_count - gen_pos;
      r = rem;
      if (rem < run_mask() && $urandom_range(0, 7) == 0) r = $urandom_range(rem + 1, run_mask());
      push_bits(r, run_width());
      gen_pos = 32'(cfg_count);
      flush_frame();
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic test_directed_frames();
      set_config(eesd_pkg::RUN_CODE_7, eesd_pkg::SUPER_RES_X1, 25'd300);
      open_frame();
      push_bits(0, 7);
      push_bits(4'hF, 4);
      push_bits(126, 7);
      push_bits(4'h0, 4);
      push_bits(127, 7);
      push_bits(45, 7);
      flush_frame();
      send_byte(8'hFF, 1'b0);
      // last event and frame end land in the same item
      set_config(eesd_pkg::RUN_CODE_7, eesd_pkg::SUPER_RES_X1, 25'd8);
      open_frame();
      push_bits(2, 7);
      push_bits(4'h5, 4);
      push_bits(0, 7);
      push_bits(4'hA, 4);
      push_bits(3, 7);
      push_bits(4'h0, 4);
      push_bits(0, 7);
      set_config(eesd_pkg::RUN_CODE_7, eesd_pkg::SUPER_RES_X1, 25'd10);
      open_frame();
      push_bits(11, 7);
      flush_frame();
      send_byte(8'h00, 1'b0);
      // a skip code that exactly reaches the count ends the frame
      set_config(eesd_pkg::RUN_CODE_7, eesd_pkg::SUPER_RES_X1, 25'd127);
      open_frame();
      push_bits(127, 7);
      flush_frame();
      for (int m = 0; m < 3; m++) begin
         case (m)
            0: set_config(eesd_pkg::RUN_CODE_8, eesd_pkg::SUPER_RES_X4,
                          eesd_pkg::FRAME_PIXEL_COUNT_RESET);
            1: set_config(eesd_pkg::RUN_CODE_7, eesd_pkg::SUPER_RES_X2,
                          eesd_pkg::FRAME_PIXEL_COUNT_RESET);
            default: set_config(eesd_pkg::RUN_CODE_8, 2'd3, eesd_pkg::FRAME_PIXEL_COUNT_RESET);
         endcase
         open_frame();
         push_bits(run_mask(), run_width());
         push_bits(run_mask() - 1, run_width());
         push_bits(4'h5, 4);
         push_bits(0, run_width());
         push_bits(4'hF, 4);
         flush_frame();
      end
   endtask

   task automatic test_mode_switch();
      set_config(eesd_pkg::RUN_CODE_7, eesd_pkg::SUPER_RES_X2, 25'd3000);
      open_frame();
      gen_events(5, 20);
      set_config(eesd_pkg::RUN_CODE_8, eesd_pkg::SUPER_RES_X2, 25'd3000);
      gen_events(5, 20);
      close_frame();
   endtask

   task automatic test_backpressure();
      set_config(eesd_pkg::RUN_CODE_7, eesd_pkg::SUPER_RES_X4, 25'd4000);
      tx_idle = 0;
      rx_idle = 0;
      rx_hold = 300;
      open_frame();
      gen_events(30, 0);
      close_frame();
      tx_idle = 1;
      rx_idle = 1;
   endtask

   task automatic test_random_frames();
      int stop_at;
      logic [24:0] pixels;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: pixels = 25'd1;
            1: pixels = 25'd2;
            default: pixels = 25'($urandom_range(3, 600));
         endcase
         set_config(p[0], 2'(p), pixels);
         stop_at = items_sent + 20;
         while (items_sent < stop_at) begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 5) == 0) settle();
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
               open_frame();
               gen_events($urandom_range(0, 8), 25);
               if ($urandom_range(0, 9) == 0) flush_frame();
               else close_frame();
            end
         end
      end
      tx_idle = 1;
      rx_idle = 1;
   endtask

   task automatic test_noise_stream();
      set_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 eesd_pkg::FRAME_PIXEL_COUNT_RESET);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (49) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
   endtask

   task automatic test_deep_frame();
      set_config(eesd_pkg::RUN_CODE_8, eesd_pkg::SUPER_RES_X4, 25'($urandom_range(12000, 14000)));
      tx_idle = 0;
      rx_idle = 0;
      open_frame();
      gen_events(40, 90);
      close_frame();
      tx_idle = 1;
      rx_idle = 1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_first_of_frame = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_frames();
      test_mode_switch();
      test_backpressure();
      test_random_frames();
      test_noise_stream();
      test_deep_frame();
      settle();
      if (mismatch_count == 0)
         $display("PASS eer_event_stream_decoder_top");
      else
         $display("FAIL eer_event_stream_decoder_top");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("FAIL eer_event_stream_decoder_top");
      $finish;
   end

endmodule
